// File: rtl/dft_pkg.sv
`default_nettype none

package dft_pkg;

  localparam int DIGIT_COUNT = 64;
  localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int DIGIT_W     = 4;
  localparam int TERM_W      = 16;

  localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(DIGIT_COUNT - 1);
  localparam logic [POS_W-1:0]   FIRST_POS = '0;
  localparam logic [DIGIT_W-1:0] RADIX     = DIGIT_W'(10);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [TERM_W-1:0]  term_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INIT = 5'b00010,
    S_ADD  = 5'b00100,
    S_RD   = 5'b01000,
    S_CHK  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/decimal_fibonacci_term.sv
`default_nettype none

// channel  | ports                                      | direction
// in_      | in_valid, in_stall, in_term_index          | request in
// out_     | out_valid, out_stall, out_digit,           | request out
//          | out_last_digit, out_overflow               |
//
// One request: accept, seed the digit memories (all DIGIT_COUNT entries), then n-2
// passes of digit adds (none for n of 2 or less; one digit per cycle through the
// memory read/write loop), then scan the digits from the top and emit them, waiting on out_stall.
// rst_n is synchronous, active low; the memories are not cleared.
// The output register holds a digit while out_stall is high; the emit scan waits
// for it. A new request is taken once the last digit is loaded.
module decimal_fibonacci_term (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  [dft_pkg::TERM_W-1:0]  in_term_index,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [dft_pkg::DIGIT_W-1:0] out_digit,
  output logic                        out_last_digit,
  output logic                        out_overflow
);

  dft_pkg::state_t state_r, state_nxt;

  dft_pkg::digit_t newer_mem [dft_pkg::DIGIT_COUNT];
  dft_pkg::digit_t older_mem [dft_pkg::DIGIT_COUNT];
  dft_pkg::digit_t rd_new_r, rd_old_r;

  dft_pkg::pos_t  ip_r, ip_nxt;
  dft_pkg::pos_t  wp_r, wp_nxt;
  dft_pkg::pos_t  p_r, p_nxt;
  dft_pkg::term_t passes_r, passes_nxt;
  logic           wv_r, wv_nxt;
  logic           seed_r, seed_nxt;
  logic           carry_r, carry_nxt;
  logic           lost_r, lost_nxt;
  logic           started_r, started_nxt;

  logic                out_valid_r;
  dft_pkg::digit_t     out_digit_r;
  logic                out_last_r;
  logic                out_ovf_r;

  logic            in_acc;
  logic            issue_en;
  logic            out_free;
  logic            load;
  logic            cin;
  logic [4:0]      sum_raw;
  logic            cout;
  dft_pkg::digit_t sum_d;
  dft_pkg::pos_t   rd_addr;
  dft_pkg::pos_t   wr_addr;
  logic            we;
  dft_pkg::digit_t wd_new, wd_old;

  assign in_stall = (state_r != dft_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign issue_en = (passes_r != '0);
  assign out_free = !out_valid_r || !out_stall;

  assign cin     = (wp_r == dft_pkg::FIRST_POS) ? 1'b0 : carry_r;
  assign sum_raw = {1'b0, rd_new_r} + {1'b0, rd_old_r} + {4'b0, cin};
  assign cout    = (sum_raw >= {1'b0, dft_pkg::RADIX});
  assign sum_d   = cout ? (sum_raw[3:0] - dft_pkg::RADIX) : sum_raw[3:0];

  assign rd_addr = (state_r == dft_pkg::S_ADD) ? ip_r : p_r;

  always_comb begin
    we      = 1'b0;
    wr_addr = wp_r;
    wd_new  = sum_d;
    wd_old  = rd_new_r;
    if (state_r == dft_pkg::S_INIT) begin
      we      = 1'b1;
      wr_addr = ip_r;
      wd_new  = (seed_r && ip_r == dft_pkg::FIRST_POS) ? dft_pkg::digit_t'(1) : '0;
      wd_old  = wd_new;
    end else if (state_r == dft_pkg::S_ADD && wv_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      newer_mem[wr_addr] <= wd_new;
      older_mem[wr_addr] <= wd_old;
    end
    rd_new_r <= newer_mem[rd_addr];
    rd_old_r <= older_mem[rd_addr];
  end

  always_comb begin
    state_nxt   = state_r;
    ip_nxt      = ip_r;
    wp_nxt      = wp_r;
    p_nxt       = p_r;
    passes_nxt  = passes_r;
    wv_nxt      = 1'b0;
    seed_nxt    = seed_r;
    carry_nxt   = carry_r;
    lost_nxt    = lost_r;
    started_nxt = started_r;
    load        = 1'b0;
    case (state_r)
      dft_pkg::S_IDLE: begin
        if (in_acc) begin
          seed_nxt    = (in_term_index != '0);
          passes_nxt  = (in_term_index > dft_pkg::term_t'(2)) ?
                        (in_term_index - dft_pkg::term_t'(2)) : '0;
          ip_nxt      = dft_pkg::FIRST_POS;
          carry_nxt   = 1'b0;
          lost_nxt    = 1'b0;
          started_nxt = 1'b0;
          state_nxt   = dft_pkg::S_INIT;
        end
      end
      dft_pkg::S_INIT: begin
        if (ip_r == dft_pkg::LAST_POS) begin
          ip_nxt    = dft_pkg::FIRST_POS;
          state_nxt = dft_pkg::S_ADD;
        end else begin
          ip_nxt = ip_r + dft_pkg::pos_t'(1);
        end
      end
      dft_pkg::S_ADD: begin
        if (wv_r) begin
          carry_nxt = cout;
          if (wp_r == dft_pkg::LAST_POS && cout) begin
            lost_nxt = 1'b1;
          end
        end
        if (issue_en) begin
          wv_nxt = 1'b1;
          wp_nxt = ip_r;
          if (ip_r == dft_pkg::LAST_POS) begin
            ip_nxt     = dft_pkg::FIRST_POS;
            passes_nxt = passes_r - dft_pkg::term_t'(1);
          end else begin
            ip_nxt = ip_r + dft_pkg::pos_t'(1);
          end
        end else if (!wv_r) begin
          p_nxt     = dft_pkg::LAST_POS;
          state_nxt = dft_pkg::S_RD;
        end
      end
      dft_pkg::S_RD: begin
        state_nxt = dft_pkg::S_CHK;
      end
      dft_pkg::S_CHK: begin
        if (!started_r && rd_new_r == '0 && p_r != dft_pkg::FIRST_POS) begin
          p_nxt     = p_r - dft_pkg::pos_t'(1);
          state_nxt = dft_pkg::S_RD;
        end else if (out_free) begin
          load        = 1'b1;
          started_nxt = 1'b1;
          if (p_r == dft_pkg::FIRST_POS) begin
            state_nxt = dft_pkg::S_IDLE;
          end else begin
            p_nxt     = p_r - dft_pkg::pos_t'(1);
            state_nxt = dft_pkg::S_RD;
          end
        end
      end
      default: begin
        state_nxt = dft_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dft_pkg::S_IDLE;
      passes_r    <= '0;
      wv_r        <= 1'b0;
      carry_r     <= 1'b0;
      lost_r      <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      passes_r  <= passes_nxt;
      wv_r      <= wv_nxt;
      carry_r   <= carry_nxt;
      lost_r    <= lost_nxt;
      started_r <= started_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ip_r   <= ip_nxt;
    wp_r   <= wp_nxt;
    p_r    <= p_nxt;
    seed_r <= seed_nxt;
    if (load) begin
      out_digit_r <= rd_new_r;
      out_last_r  <= (p_r == dft_pkg::FIRST_POS);
      out_ovf_r   <= lost_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit      = out_digit_r;
  assign out_last_digit = out_last_r;
  assign out_overflow   = out_ovf_r;

  a_decimal_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_digit_r <= 4'd9))
    else $error("emitted digit is not decimal");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dft_pkg::S_ADD) && wv_r && issue_en |-> (wp_r != ip_r))
    else $error("digit write and read hit the same entry");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> (state_r != dft_pkg::S_IDLE))
    else $error("block idle with an unfinished digit run");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/decimal_fibonacci_term_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
  dft_pkg::digit_t digit;
  logic            last_digit;
  logic            overflow;
} term_digit_t;

class fib_term_board;
  term_digit_t digits_due[$];
  int          failures;
  int          terms_noted;
  int          digits_checked;
  int          wrapped_terms;
  int          top_index;

  function new();
    failures       = 0;
    terms_noted    = 0;
    digits_checked = 0;
    wrapped_terms  = 0;
    top_index      = 0;
  endfunction

  function int pending();
    return digits_due.size();
  endfunction

  // BCD ripple add of the two term stores, n-2 times, then emit MSD first.
  function void note_term(dft_pkg::term_t n);
    dft_pkg::digit_t newer [dft_pkg::DIGIT_COUNT];
    dft_pkg::digit_t older [dft_pkg::DIGIT_COUNT];
    term_digit_t     rec;
    logic            carry;
    logic            wrapped;
    int unsigned     done;
    int              sum;
    int              top;
    for (int i = 0; i < dft_pkg::DIGIT_COUNT; i++) begin
      newer[i] = '0;
      older[i] = '0;
    end
    wrapped = 1'b0;
    if (n != '0) begin
      newer[0] = dft_pkg::digit_t'(1);
      older[0] = dft_pkg::digit_t'(1);
      done = (n == 1) ? 1 : 2;
      while (done < n) begin
        carry = 1'b0;
        for (int i = 0; i < dft_pkg::DIGIT_COUNT; i++) begin
          sum = int'(newer[i]) + int'(older[i]) + int'(carry);
          older[i] = newer[i];
          carry = (sum >= int'(dft_pkg::RADIX));
          newer[i] = dft_pkg::digit_t'(carry ? sum - int'(dft_pkg::RADIX) : sum);
        end
        if (carry) wrapped = 1'b1;
        done++;
      end
    end
    top = dft_pkg::DIGIT_COUNT - 1;
    while (top > 0 && newer[top] == '0) top--;
    for (int i = top; i >= 0; i--) begin
      rec.digit      = newer[i];
      rec.last_digit = (i == 0);
      rec.overflow   = wrapped;
      digits_due.push_back(rec);
    end
    terms_noted++;
    if (wrapped) wrapped_terms++;
    if (int'(n) > top_index) top_index = int'(n);
  endfunction

  function void check_digit(dft_pkg::digit_t d, logic last_digit, logic overflow);
    term_digit_t got;
    term_digit_t want;
    got = {d, last_digit, overflow};
    if (digits_due.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("%0t: unexpected digit %0d last %0b ovf %0b", $realtime, d, last_digit,
                 overflow);
      return;
    end
    want = digits_due.pop_front();
    digits_checked++;
    if (got !== want) begin
      failures++;
      if (failures <= 10)
        $display("%0t: digit mismatch exp d=%0d last=%0b ovf=%0b got d=%0d last=%0b ovf=%0b",
                 $realtime, want.digit, want.last_digit, want.overflow,
                 got.digit, got.last_digit, got.overflow);
    end
  endfunction
endclass

module decimal_fibonacci_term_tb;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  dft_pkg::term_t         in_term_index;
  logic                   out_valid;
  logic                   out_stall;
  dft_pkg::digit_t        out_digit;
  logic                   out_last_digit;
  logic                   out_overflow;

  fib_term_board board;
  int            cycle_count = 0;
  int            stall_left  = 0;

  decimal_fibonacci_term dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_term_index  (in_term_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit      (out_digit),
    .out_last_digit (out_last_digit),
    .out_overflow   (out_overflow)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_term(in_term_index);
      if (out_valid && !out_stall) board.check_digit(out_digit, out_last_digit, out_overflow);
    end
  end

  // receiver back-pressure; one window of cycle_count in every four starts no new stalls
  always @(posedge clk) begin
    int r;
    cycle_count <= cycle_count + 1;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ((cycle_count / 700) % 4 != 3 && r < 20)
        stall_left <= (r < 2) ? $urandom_range(20, 60) : $urandom_range(1, 4);
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic dft_pkg::term_t pick_term();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return dft_pkg::term_t'($urandom_range(0, 3));
    if (r < 80) return dft_pkg::term_t'($urandom_range(3, 320));
    if (r < 95) return dft_pkg::term_t'($urandom_range(300, 700));
    return dft_pkg::term_t'($urandom_range(700, 1500));
  endfunction

  task automatic send_term(input dft_pkg::term_t n, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_term_index <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_terms();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    int directed_terms [$];
    board = new();
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_term_index <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero term, the two seeds, small terms, 64-digit edge and wrap, all-ones index
    directed_terms = '{0, 1, 2, 3, 4, 5, 10, 12, 45, 93, 100, 306, 307, 308, 309, 310,
                       400, 1000, 65535};
    foreach (directed_terms[i])
      send_term(dft_pkg::term_t'(directed_terms[i]), (i % 3 == 1) ? pick_gap(1'b0) : 0);
    drain_terms();

    for (int k = 0; k < 80; k++) begin
      send_term(pick_term(), pick_gap((k / 16) % 3 == 2));
      if ($urandom_range(0, 99) < 5) drain_terms();
    end
    drain_terms();
    repeat (300) @(posedge clk);

    $display("covered %0d terms up to index %0d, %0d digits checked",
             board.terms_noted, board.top_index, board.digits_checked);
    $display("%0d terms wrapped past the top digit, %0d mismatches",
             board.wrapped_terms, board.failures);
    if (board.failures == 0 && board.pending() == 0)
      $display("decimal_fibonacci_term_tb passed");
    else
      $display("decimal_fibonacci_term_tb failed");
    $finish;
  end

  initial begin
    #300000000;
    $display("decimal_fibonacci_term_tb failed");
    $finish;
  end

endmodule

// File: files.f
rtl/dft_pkg.sv
rtl/decimal_fibonacci_term.sv
tb/decimal_fibonacci_term_tb.sv
